/* rtl/adp_pkg.sv */
// package for the aml data object parser
// shared types, opcode classes, result kinds and parse modes; no dependencies
`default_nettype none

package adp_pkg;

    // aml opcodes
    localparam logic [7:0] OP_ZERO     = 8'h00;
    localparam logic [7:0] OP_ONE      = 8'h01;
    localparam logic [7:0] OP_ONES     = 8'hFF;
    localparam logic [7:0] OP_BYTE     = 8'h0A;
    localparam logic [7:0] OP_WORD     = 8'h0B;
    localparam logic [7:0] OP_DWORD    = 8'h0C;
    localparam logic [7:0] OP_STRING   = 8'h0D;
    localparam logic [7:0] OP_QWORD    = 8'h0E;
    localparam logic [7:0] OP_BUFFER   = 8'h11;
    localparam logic [7:0] OP_EXT      = 8'h5B;
    localparam logic [7:0] OP_REVISION = 8'h30;

    // result kinds
    localparam logic [3:0] KIND_ZERO       = 4'd0;
    localparam logic [3:0] KIND_ONE        = 4'd1;
    localparam logic [3:0] KIND_ONES       = 4'd2;
    localparam logic [3:0] KIND_BYTE       = 4'd3;
    localparam logic [3:0] KIND_REVISION   = 4'd7;
    localparam logic [3:0] KIND_CHAR       = 4'd8;
    localparam logic [3:0] KIND_STR_END    = 4'd9;
    localparam logic [3:0] KIND_BUFFER     = 4'd10;
    localparam logic [3:0] KIND_PREFIX_ERR = 4'd11;
    localparam logic [3:0] KIND_PARSE_ERR  = 4'd12;

    localparam logic [7:0] LIMIT_RESET = 8'd127;

    // class of a byte when read as an opcode
    typedef enum logic [2:0] {
        OPC_ZERO,
        OPC_ONE,
        OPC_ONES,
        OPC_INT,
        OPC_STRING,
        OPC_EXT,
        OPC_BUFFER,
        OPC_UNKNOWN
    } t_op_class;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_STRING,
        MODE_EXT
    } t_parse_mode;

    // one classified item passed from front to back
    typedef struct packed {
        logic [7:0] data;
        t_op_class  op;
        logic [1:0] int_kind;
        logic       is_nul;
        logic       is_revision;
        logic       over_limit;
    } t_cls_item;

endpackage

`default_nettype wire

/* rtl/adp_front.sv */
// front end: holds the string character limit and classifies each byte
// depends on adp_pkg
`default_nettype none

module adp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [7:0]       i_cfg_wr_data,
    input  wire logic [7:0]       i_stream_byte,
    output adp_pkg::t_cls_item    o_item
);
    import adp_pkg::*;

    logic [7:0] r_limit;
    t_op_class  op;
    logic [1:0] int_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_comb begin
        int_kind = 2'd0;
        case (i_stream_byte)
            OP_ZERO:   op = OPC_ZERO;
            OP_ONE:    op = OPC_ONE;
            OP_ONES:   op = OPC_ONES;
            OP_BYTE: begin
                op = OPC_INT;
                int_kind = 2'd0;
            end
            OP_WORD: begin
                op = OPC_INT;
                int_kind = 2'd1;
            end
            OP_DWORD: begin
                op = OPC_INT;
                int_kind = 2'd2;
            end
            OP_QWORD: begin
                op = OPC_INT;
                int_kind = 2'd3;
            end
            OP_STRING: op = OPC_STRING;
            OP_EXT:    op = OPC_EXT;
            OP_BUFFER: op = OPC_BUFFER;
            default:   op = OPC_UNKNOWN;
        endcase
    end

    assign o_item.data        = i_stream_byte;
    assign o_item.op          = op;
    assign o_item.int_kind    = int_kind;
    assign o_item.is_nul      = (i_stream_byte == 8'd0);
    assign o_item.is_revision = (i_stream_byte == OP_REVISION);
    assign o_item.over_limit  = (i_stream_byte > r_limit);

endmodule

`default_nettype wire

/* rtl/adp_queue.sv */
// two-entry queue of classified items between front and back
// depends on adp_pkg
`default_nettype none

module adp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  adp_pkg::t_cls_item    i_item,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_nonempty,
    output adp_pkg::t_cls_item    o_item
);
    import adp_pkg::*;

    t_cls_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_item     = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* rtl/adp_back.sv */
// back end: parse state machine, integer assembly and the output register
// depends on adp_pkg
`default_nettype none

module adp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_item_valid,
    input  adp_pkg::t_cls_item    i_item,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [3:0]            o_object_kind,
    output logic [63:0]           o_object_value,
    output logic                  o_object_done
);
    import adp_pkg::*;

    t_parse_mode r_mode, n_mode;
    logic [3:0]  r_left, n_left;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_int_kind, n_int_kind;

    logic        r_out_valid;
    logic [3:0]  r_kind;
    logic [63:0] r_value;
    logic        r_done;

    logic        emit;
    logic [3:0]  emit_kind;
    logic [63:0] emit_value;
    logic        emit_done;
    logic [63:0] acc_merged;
    logic [3:0]  left_dec;

    // back can take an item when the output slot is free or draining
    assign o_pop = i_item_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            acc_merged[k*8 +: 8] = r_acc[k*8 +: 8]
                | ((r_pos == 3'(k)) ? i_item.data : 8'd0);
        end
        left_dec = r_left - 4'd1;
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_left     = r_left;
        n_pos      = r_pos;
        n_acc      = r_acc;
        n_int_kind = r_int_kind;
        case (r_mode)
            MODE_INT: begin
                n_acc  = acc_merged;
                n_pos  = r_pos + 3'd1;
                n_left = left_dec;
                if (left_dec == 4'd0) n_mode = MODE_IDLE;
            end
            MODE_STRING: begin
                if (i_item.is_nul || i_item.over_limit) n_mode = MODE_IDLE;
            end
            MODE_EXT: n_mode = MODE_IDLE;
            default: begin
                n_mode = MODE_IDLE;
                case (i_item.op)
                    OPC_INT: begin
                        n_mode     = MODE_INT;
                        n_int_kind = i_item.int_kind;
                        n_left     = 4'd1 << i_item.int_kind;
                        n_pos      = 3'd0;
                        n_acc      = 64'd0;
                    end
                    OPC_STRING: n_mode = MODE_STRING;
                    OPC_EXT:    n_mode = MODE_EXT;
                    default:    n_mode = MODE_IDLE;
                endcase
            end
        endcase
    end

    // result of the current item
    always_comb begin
        emit       = 1'b0;
        emit_kind  = KIND_PREFIX_ERR;
        emit_value = 64'd0;
        emit_done  = 1'b1;
        case (r_mode)
            MODE_INT: begin
                if (left_dec == 4'd0) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_BYTE + {2'b00, r_int_kind};
                    emit_value = acc_merged;
                end
            end
            MODE_STRING: begin
                emit = 1'b1;
                if (i_item.is_nul) begin
                    emit_kind = KIND_STR_END;
                end else if (i_item.over_limit) begin
                    emit_kind = KIND_PARSE_ERR;
                end else begin
                    emit_kind  = KIND_CHAR;
                    emit_value = {56'd0, i_item.data};
                    emit_done  = 1'b0;
                end
            end
            MODE_EXT: begin
                emit      = 1'b1;
                emit_kind = i_item.is_revision ? KIND_REVISION : KIND_PREFIX_ERR;
            end
            default: begin
                case (i_item.op)
                    OPC_ZERO: begin
                        emit      = 1'b1;
                        emit_kind = KIND_ZERO;
                    end
                    OPC_ONE: begin
                        emit      = 1'b1;
                        emit_kind = KIND_ONE;
                    end
                    OPC_ONES: begin
                        emit      = 1'b1;
                        emit_kind = KIND_ONES;
                    end
                    OPC_BUFFER: begin
                        emit      = 1'b1;
                        emit_kind = KIND_BUFFER;
                    end
                    OPC_UNKNOWN: begin
                        emit      = 1'b1;
                        emit_kind = KIND_PREFIX_ERR;
                    end
                    default: emit = 1'b0;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_left      <= 4'd0;
            r_pos       <= 3'd0;
            r_acc       <= 64'd0;
            r_int_kind  <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode     <= n_mode;
                r_left     <= n_left;
                r_pos      <= n_pos;
                r_acc      <= n_acc;
                r_int_kind <= n_int_kind;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind  <= emit_kind;
            r_value <= emit_value;
            r_done  <= emit_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_object_kind  = r_kind;
    assign o_object_value = r_value;
    assign o_object_done  = r_done;

endmodule

`default_nettype wire

/* rtl/aml_data_object_parser.sv */
// top level of the aml data object parser
// depends on adp_pkg, adp_front, adp_queue and adp_back
`default_nettype none

// decodes acpi aml computational data objects from a byte stream, one byte
// per item. zero, one and ones opcodes each give one result; byte, word,
// dword and qword prefixes give one result carrying the little-endian
// integer once its last byte has arrived; the extended prefix gives a
// revision result or a prefix error; a string gives one result per
// character (object_done low) and a string end, or a parse error when a
// character exceeds the configured limit. the buffer opcode is reported only.
// the block sustains one byte per cycle on both sides unless the receiver
// stalls: the front classifies a byte as it is accepted, a two-entry queue
// holds it, and the back state machine consumes one queued item per cycle
// into a single output register. the string character limit resets to 127;
// the user writes it through i_cfg_wr_en / i_cfg_wr_data only while the
// block is idle, which the block itself does not enforce.

module aml_data_object_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_stream_byte,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_object_kind,
    output logic [63:0]      o_object_value,
    output logic             o_object_done
);
    import adp_pkg::*;

    t_cls_item front_item;
    t_cls_item queue_item;
    logic      queue_full;
    logic      queue_nonempty;
    logic      push;
    logic      pop;

    // accept whenever the queue has room
    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    // classify the byte and hold the character limit
    adp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stream_byte (i_stream_byte),
        .o_item        (front_item)
    );

    // decouples input stall from output stall
    adp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_nonempty (queue_nonempty),
        .o_item     (queue_item)
    );

    // parse state machine and output register
    adp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (queue_nonempty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_object_kind  (o_object_kind),
        .o_object_value (o_object_value),
        .o_object_done  (o_object_done)
    );

endmodule

`default_nettype wire

/* tb/adp_checker.sv */
// result checker for the aml data object parser testbench
// watches the config, input and result channels, predicts every result and compares
// depends on adp_pkg
module adp_checker
    import adp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_object_kind,
    input  logic [63:0] i_object_value,
    input  logic        i_object_done,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic        done;
    } aml_result_t;

    // predicted decoder state
    t_parse_mode cur_mode;
    logic [3:0]  bytes_left;
    logic [2:0]  byte_pos;
    logic [63:0] int_acc;
    logic [1:0]  int_kind;
    logic [7:0]  char_limit;

    aml_result_t objects_due[$];
    aml_result_t want;
    aml_result_t got;
    int          reports;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        reports      = 0;
    end

    // advances the predicted state by one stream byte; returns 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] b, output aml_result_t r);
        r = '0;
        r.done = 1'b1;
        case (cur_mode)
            MODE_INT: begin
                int_acc    = int_acc | ({56'd0, b} << (8 * byte_pos));
                byte_pos   = byte_pos + 3'd1;
                bytes_left = bytes_left - 4'd1;
                if (bytes_left != 4'd0)
                    return 1'b0;
                cur_mode = MODE_IDLE;
                r.kind   = KIND_BYTE + {2'b00, int_kind};
                r.value  = int_acc;
                return 1'b1;
            end
            MODE_STRING: begin
                if (b == 8'd0) begin
                    cur_mode = MODE_IDLE;
                    r.kind   = KIND_STR_END;
                end else if (b > char_limit) begin
                    cur_mode = MODE_IDLE;
                    r.kind   = KIND_PARSE_ERR;
                end else begin
                    r.kind  = KIND_CHAR;
                    r.value = {56'd0, b};
                    r.done  = 1'b0;
                end
                return 1'b1;
            end
            MODE_EXT: begin
                cur_mode = MODE_IDLE;
                r.kind   = (b == OP_REVISION) ? KIND_REVISION : KIND_PREFIX_ERR;
                return 1'b1;
            end
            default: ;
        endcase

        // idle: the byte is an opcode
        cur_mode = MODE_IDLE;
        case (b)
            OP_ZERO:   r.kind = KIND_ZERO;
            OP_ONE:    r.kind = KIND_ONE;
            OP_ONES:   r.kind = KIND_ONES;
            OP_BUFFER: r.kind = KIND_BUFFER;
            OP_BYTE, OP_WORD, OP_DWORD, OP_QWORD: begin
                int_kind   = (b == OP_QWORD) ? 2'd3 : 2'(b - OP_BYTE);
                bytes_left = 4'd1 << int_kind;
                byte_pos   = 3'd0;
                int_acc    = 64'd0;
                cur_mode   = MODE_INT;
                return 1'b0;
            end
            OP_STRING: begin
                cur_mode = MODE_STRING;
                return 1'b0;
            end
            OP_EXT: begin
                cur_mode = MODE_EXT;
                return 1'b0;
            end
            default:   r.kind = KIND_PREFIX_ERR;
        endcase
        return 1'b1;
    endfunction

    task automatic note_failure(input string what);
        o_fail_count++;
        if (reports < REPORT_MAX) begin
            reports++;
            $display("%0t: %s: expected kind %0d value %h done %0d, got kind %0d value %h done %0d",
                     $realtime, what, want.kind, want.value, want.done,
                     got.kind, got.value, got.done);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode   = MODE_IDLE;
            bytes_left = 4'd0;
            byte_pos   = 3'd0;
            int_acc    = 64'd0;
            int_kind   = 2'd0;
            char_limit = LIMIT_RESET;
            objects_due.delete();
        end else begin
            // results first, so a result never matches the byte taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                got = '{i_object_kind, i_object_value, i_object_done};
                if (objects_due.size() == 0) begin
                    want = '0;
                    note_failure("result with nothing expected");
                end else begin
                    want = objects_due.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value
                        || got.done !== want.done)
                        note_failure("result mismatch");
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_byte(i_stream_byte, want))
                    objects_due.push_back(want);
            end
            if (i_cfg_wr_en)
                char_limit = i_cfg_wr_data;
        end
        o_pending = objects_due.size();
    end

endmodule

/* tb/tb_top.sv */
// top of the aml data object parser testbench: clock, reset, stimulus and verdict
// drives aml_data_object_parser and checks it through adp_checker
// depends on adp_pkg, adp_checker and the rtl of the block
module tb_top;
    import adp_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEMS          = 1150;
    localparam int N_PHASES       = 6;
    // extra wait after the last predicted result; covers queued bytes with no result
    localparam int DRAIN_CYCLES   = 8;
    // long receiver hold-off, well beyond what the internal queue can absorb
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_ITEMS     = 40;
    // no acceptance for this long means the block hung
    localparam int WATCHDOG_LIMIT = 2000;

    // bytes for the directed part that are not named opcodes
    localparam logic [7:0] UNKNOWN_OP  = 8'h42;
    localparam logic [7:0] BAD_EXT_OP  = 8'h31;
    localparam logic [7:0] CHAR_A      = 8'h41;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_stream_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [3:0]  o_object_kind;
    logic [63:0] o_object_value;
    logic        o_object_done;

    int          check_failures;
    int          objects_pending;

    // idling and long_hold_req are shared between stimulus and the receiver process
    bit          idling        = 1'b1;
    bit          long_hold_req = 1'b0;
    int          items_sent    = 0;

    aml_data_object_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_stream_byte  (i_stream_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_object_kind  (o_object_kind),
        .o_object_value (o_object_value),
        .o_object_done  (o_object_done)
    );

    adp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_stream_byte  (i_stream_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_object_kind  (o_object_kind),
        .i_object_value (o_object_value),
        .i_object_done  (o_object_done),
        .o_fail_count   (check_failures),
        .o_pending      (objects_pending)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // offers one byte, sometimes after a random gap, and holds it until taken
    task automatic push_byte(input logic [7:0] b);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // sender pauses until every predicted result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the checker log the last byte before its pending count is read
        @(posedge i_clk);
        while (objects_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block drained
    task automatic set_char_limit(input logic [7:0] lim);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // integer payload bytes, biased toward all zeros and all ones
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one object, mostly well formed with random content, some noise
    task automatic send_random_object(input logic [7:0] lim);
        int         pick;
        int         k;
        int         len;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            // single-byte constants and the buffer opcode
            case ($urandom_range(0, 3))
                0:       push_byte(OP_ZERO);
                1:       push_byte(OP_ONE);
                2:       push_byte(OP_ONES);
                default: push_byte(OP_BUFFER);
            endcase
        end else if (pick < 9) begin
            k = $urandom_range(0, 3);
            case (k)
                0:       push_byte(OP_BYTE);
                1:       push_byte(OP_WORD);
                2:       push_byte(OP_DWORD);
                default: push_byte(OP_QWORD);
            endcase
            repeat (1 << k) push_byte(payload_byte());
        end else if (pick < 15) begin
            // string: legal chars, occasionally one over the limit (always at limit 0), which aborts it
            push_byte(OP_STRING);
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
                if (lim != 8'h00 && (lim == 8'hFF || $urandom_range(0, 24) != 0))
                    c = 8'($urandom_range(1, lim));
                else
                    c = 8'($urandom_range(int'(lim) + 1, 255));
                push_byte(c);
                if (c > lim)
                    return;
            end
            push_byte(8'h00);
        end else if (pick < 17) begin
            push_byte(OP_EXT);
            if ($urandom_range(0, 3) != 0)
                push_byte(OP_REVISION);
            else
                push_byte(8'($urandom_range(0, 255)));
        end else begin
            // raw noise, may start or break any sequence
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int burst;
        burst = 0;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                burst         = LONG_HOLD;
            end else if (burst == 0 && idling && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 10);
            end
            i_out_stall <= (burst != 0);
            if (burst != 0)
                burst--;
            @(posedge i_clk);
        end
    end

    // hang detection: cycles with no item moving on any channel
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus
    initial begin
        logic [7:0] lim;
        int         base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset limit of 127
        push_byte(OP_ZERO);
        push_byte(OP_ONE);
        push_byte(OP_ONES);
        push_byte(OP_BUFFER);
        push_byte(UNKNOWN_OP);          // unknown opcode, stays idle
        push_byte(OP_EXT);
        push_byte(OP_REVISION);
        push_byte(OP_EXT);              // bad extended opcode
        push_byte(BAD_EXT_OP);
        push_byte(OP_STRING);           // empty string
        push_byte(8'h00);
        push_byte(OP_STRING);           // char, char at limit, then one above it
        push_byte(CHAR_A);
        push_byte(LIMIT_RESET);
        push_byte(LIMIT_RESET + 8'd1);
        push_byte(OP_BYTE);
        push_byte(8'hFF);
        push_byte(OP_QWORD);            // byte order check
        push_byte(8'h01);
        push_byte(8'h23);
        push_byte(8'h45);
        push_byte(8'h67);
        push_byte(8'h89);
        push_byte(8'hAB);
        push_byte(8'hCD);
        push_byte(8'hEF);
        drain_results();

        // receiver holds off while the sender keeps offering, so the input backs up
        long_hold_req = 1'b1;
        repeat (HOLD_ITEMS) push_byte(($urandom_range(0, 1) != 0) ? OP_ZERO : OP_ONES);
        drain_results();

        // random phases, each at its own limit; extremes first, middle and last
        // phases run without idling
        base = items_sent;
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       lim = 8'h00;
                1:       lim = 8'hFF;
                3:       lim = 8'h20;
                default: lim = 8'($urandom_range(0, 255));
            endcase
            set_char_limit(lim);
            idling = !(p == 2 || p == N_PHASES - 1);
            while (items_sent < base + (p + 1) * (ITEMS - base) / N_PHASES)
                send_random_object(lim);
            drain_results();
        end

        if (check_failures == 0 && objects_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/adp_pkg.sv
rtl/adp_front.sv
rtl/adp_queue.sv
rtl/adp_back.sv
rtl/aml_data_object_parser.sv
tb/adp_checker.sv
tb/tb_top.sv
